### rtl/mpqe_pkg.sv
// ----------------------------------------------------------------------------
// mpqe_pkg
// Shared types and constants of the mailbox port queue engine.
// ----------------------------------------------------------------------------
package mpqe_pkg;

  localparam int unsigned NumPortsDef   = 16;
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned MsgBytesDef   = 8;

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_DESTROY = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RECV    = 3'd3,
    CMD_TRYRECV = 3'd4,
    CMD_STATS   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ERR     = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BLOCKED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_OUT
  } state_e;

  // Keep the low n bytes of a word.
  function automatic logic [63:0] byte_mask(input logic [7:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (n > 8'(b)) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

### rtl/mpqe_slot_ram.sv
// ----------------------------------------------------------------------------
// mpqe_slot_ram
// Message slot storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mpqe_slot_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [115:0]     wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [115:0]     rdata_o
);
  logic [115:0] mem [Depth];

  // Read data holds its value while the read enable is low.
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[raddr_i];
  end
endmodule

### rtl/mailbox_port_queue_engine.sv
// ----------------------------------------------------------------------------
// mailbox_port_queue_engine
// Mailbox with per-port circular message queues, driven one command word at
// a time by a small sequencer around a shared port scan unit.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Content
// cmd     | in        | in_valid_i/in_stall_o | command word
// result  | out       | out_valid_o/out_stall_i | status and message word
//
// A create or stats word walks the port table one port per cycle in the scan
// state before it executes; other commands go from idle straight to execute.
// The slot memory read is registered in execute, so the read data is ready in
// the result state. The block takes a new word only in idle, to which it returns
// after each result handshake, so a new word never overlaps the last one.
// Reset clears all port state and the message counter; the slot memory is not
// cleared. A stalled result holds the block, and the read data with it, and
// no new word is taken until the result is taken.
module mailbox_port_queue_engine
  import mpqe_pkg::*;
#(
  parameter int unsigned NUM_PORTS   = NumPortsDef,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned MSG_BYTES   = MsgBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [15:0] caller_pid_i,
  input  logic [7:0]  port_i,
  input  logic [31:0] msg_type_i,
  input  logic [7:0]  msg_size_i,
  input  logic [63:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  port_out_o,
  output logic [15:0] msg_sender_o,
  output logic [31:0] recv_type_o,
  output logic [3:0]  recv_size_o,
  output logic [63:0] recv_payload_o,
  output logic        wake_valid_o,
  output logic [15:0] wake_pid_o,
  output logic [4:0]  ports_used_o,
  output logic [4:0]  blocked_ports_o,
  output logic [31:0] msg_count_o
);
  localparam int unsigned PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = PW + QW;
  localparam int unsigned NW = $clog2(NUM_PORTS + 1);

  // Per-port table, held in flip-flops.
  logic [NUM_PORTS-1:0] in_use_q, wait_q;
  logic [15:0]   owner_q [NUM_PORTS];
  logic [15:0]   wpid_q  [NUM_PORTS];
  logic [QW-1:0] head_q  [NUM_PORTS];
  logic [QW-1:0] tail_q  [NUM_PORTS];
  logic [CW-1:0] cnt_q   [NUM_PORTS];
  logic [31:0]   sent_q;

  state_e state_q, state_d;

  // Latched command word.
  logic [2:0]  cmd_q;
  logic [15:0] pid_q;
  logic [7:0]  port_q;
  logic [31:0] type_q;
  logic [7:0]  size_q;
  logic [63:0] data_q;

  // Scan unit: index, found flag, counters.
  logic [PW-1:0] idx_q;
  logic          found_q;
  logic [PW-1:0] fidx_q;
  logic [NW-1:0] act_q, blk_q;

  // Result register.
  logic [1:0]  st_q;
  logic [3:0]  pout_q;
  logic        deq_q;
  logic        wv_q;
  logic [15:0] wp_q;

  logic [PW-1:0] p;
  logic          vport, inuse, owned, empty, full, okcmd;
  assign p     = port_q[PW-1:0];
  assign vport = {24'd0, port_q} < 32'(NUM_PORTS);
  assign inuse = vport && in_use_q[p];
  assign owned = inuse && (owner_q[p] == pid_q);
  assign empty = cnt_q[p] == '0;
  assign full  = 32'(cnt_q[p]) >= 32'(QUEUE_DEPTH);
  assign okcmd = cmd_q <= 3'(CMD_STATS);

  logic last;
  assign last = 32'(idx_q) == 32'(NUM_PORTS - 1);

  // Slot memory. The address is port and queue index side by side, so the
  // memory spans the full address range.
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [115:0]  wdata, rdata;
  assign we    = state_q == S_EXEC && cmd_q == 3'(CMD_SEND) && inuse &&
                 size_q <= 8'(MSG_BYTES) && !full;
  assign re    = state_q == S_EXEC;
  assign waddr = {p, tail_q[p]};
  assign raddr = {p, head_q[p]};
  assign wdata = {pid_q, type_q, size_q[3:0], data_q & byte_mask(size_q)};

  mpqe_slot_ram #(.Depth(2 ** AW), .AddrW(AW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(re), .raddr_i(raddr), .rdata_o(rdata)
  );

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = state_q == S_OUT;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        state_d = (cmd_i == 3'(CMD_CREATE) || cmd_i == 3'(CMD_STATS)) ? S_SCAN : S_EXEC;
      end
      S_SCAN: if (last) state_d = S_EXEC;
      S_EXEC: state_d = S_OUT;
      S_OUT:  if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    status_o        = st_q;
    port_out_o      = pout_q;
    msg_sender_o    = deq_q ? rdata[115:100] : '0;
    recv_type_o     = deq_q ? rdata[99:68] : '0;
    recv_size_o     = deq_q ? rdata[67:64] : '0;
    recv_payload_o  = deq_q ? rdata[63:0] : '0;
    wake_valid_o    = wv_q;
    wake_pid_o      = wp_q;
    ports_used_o    = '0;
    blocked_ports_o = '0;
    msg_count_o     = '0;
    if (cmd_q == 3'(CMD_STATS)) begin
      ports_used_o    = 5'(act_q);
      blocked_ports_o = 5'(blk_q);
      msg_count_o     = sent_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      in_use_q <= '0;
      wait_q   <= '0;
      sent_q   <= '0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        owner_q[i] <= '0;
        wpid_q[i]  <= '0;
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        cnt_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC && okcmd) begin
        unique case (cmd_e'(cmd_q))
          CMD_CREATE: if (found_q) begin
            in_use_q[fidx_q] <= 1'b1;
            owner_q[fidx_q]  <= pid_q;
            head_q[fidx_q]   <= '0;
            tail_q[fidx_q]   <= '0;
            cnt_q[fidx_q]    <= '0;
            wait_q[fidx_q]   <= 1'b0;
          end
          CMD_DESTROY: if (owned) begin
            wait_q[p]   <= 1'b0;
            in_use_q[p] <= 1'b0;
            owner_q[p]  <= '0;
            cnt_q[p]    <= '0;
          end
          CMD_SEND: if (we) begin
            tail_q[p] <= (32'(tail_q[p]) == 32'(QUEUE_DEPTH - 1)) ? '0 : tail_q[p] + 1'b1;
            cnt_q[p]  <= cnt_q[p] + 1'b1;
            sent_q    <= sent_q + 1'b1;
            wait_q[p] <= 1'b0;
          end
          CMD_RECV, CMD_TRYRECV: if (owned) begin
            if (empty) begin
              if (cmd_q == 3'(CMD_RECV)) begin
                wait_q[p] <= 1'b1;
                wpid_q[p] <= pid_q;
              end
            end else begin
              head_q[p] <= (32'(head_q[p]) == 32'(QUEUE_DEPTH - 1)) ? '0 : head_q[p] + 1'b1;
              cnt_q[p]  <= cnt_q[p] - 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Command latch, scan unit and result register.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      cmd_q   <= cmd_i;
      pid_q   <= caller_pid_i;
      port_q  <= port_i;
      type_q  <= msg_type_i;
      size_q  <= msg_size_i;
      data_q  <= payload_i;
      idx_q   <= '0;
      found_q <= 1'b0;
      fidx_q  <= '0;
      act_q   <= '0;
      blk_q   <= '0;
    end
    if (state_q == S_SCAN) begin
      if (!in_use_q[idx_q] && !found_q) begin
        found_q <= 1'b1;
        fidx_q  <= idx_q;
      end
      if (in_use_q[idx_q]) begin
        act_q <= act_q + 1'b1;
        if (wait_q[idx_q]) blk_q <= blk_q + 1'b1;
      end
      if (!last) idx_q <= idx_q + 1'b1;
    end
    if (state_q == S_EXEC) begin
      st_q   <= 2'(ST_ERR);
      pout_q <= '0;
      deq_q  <= 1'b0;
      wv_q   <= 1'b0;
      wp_q   <= '0;
      if (okcmd) begin
        unique case (cmd_e'(cmd_q))
          CMD_CREATE: if (found_q) begin
            st_q   <= 2'(ST_OK);
            pout_q <= 4'(fidx_q);
          end
          CMD_DESTROY: if (owned) begin
            st_q <= 2'(ST_OK);
            wv_q <= wait_q[p];
            wp_q <= wait_q[p] ? wpid_q[p] : '0;
          end
          CMD_SEND: if (we) begin
            st_q <= 2'(ST_OK);
            wv_q <= wait_q[p];
            wp_q <= wait_q[p] ? wpid_q[p] : '0;
          end
          CMD_RECV, CMD_TRYRECV: if (owned) begin
            if (empty) begin
              st_q <= (cmd_q == 3'(CMD_RECV)) ? 2'(ST_BLOCKED) : 2'(ST_EMPTY);
            end else begin
              st_q  <= 2'(ST_OK);
              deq_q <= 1'b1;
            end
          end
          CMD_STATS: st_q <= 2'(ST_OK);
          default: ;
        endcase
      end
    end
  end
endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// Mailbox port queue engine testbench
// Drives command words into the engine and keeps a behavioral copy of every
// port, queue and waiter. Each accepted word is turned into its expected reply
// at the moment of acceptance. Each reply taken from the engine is compared
// field by field with the oldest expected reply.
// ----------------------------------------------------------------------------
module tb;
  import mpqe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Ports = NumPortsDef;
  localparam int unsigned Depth = QueueDepthDef;
  localparam int unsigned WordTarget = 1100;
  localparam int unsigned QuietFrom = 950;
  localparam int unsigned StuckLimit = 3000;
  localparam int unsigned DrainCycles = 40;
  // Command codes that the engine does not define.
  localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] pid;
    logic [7:0]  port;
    logic [31:0] mtype;
    logic [7:0]  size;
    logic [63:0] data;
  } mbx_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  port_out;
    logic [15:0] sender;
    logic [31:0] rtype;
    logic [3:0]  rsize;
    logic [63:0] rdata;
    logic        wake_valid;
    logic [15:0] wake_pid;
    logic [4:0]  active;
    logic [4:0]  blocked;
    logic [31:0] total;
  } mbx_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = '0;
  logic [15:0] caller_pid_i = '0;
  logic [7:0]  port_i = '0;
  logic [31:0] msg_type_i = '0;
  logic [7:0]  msg_size_i = '0;
  logic [63:0] payload_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  port_out_o;
  logic [15:0] msg_sender_o;
  logic [31:0] recv_type_o;
  logic [3:0]  recv_size_o;
  logic [63:0] recv_payload_o;
  logic        wake_valid_o;
  logic [15:0] wake_pid_o;
  logic [4:0]  ports_used_o;
  logic [4:0]  blocked_ports_o;
  logic [31:0] msg_count_o;

  mailbox_port_queue_engine i_dut (.*);

  // Shadow copy of the engine state, updated as each word is accepted.
  logic        mb_in_use [Ports];
  logic [15:0] mb_owner [Ports];
  logic [3:0]  mb_head [Ports];
  logic [3:0]  mb_tail [Ports];
  logic [4:0]  mb_count [Ports];
  logic        mb_waiting [Ports];
  logic [15:0] mb_waiter [Ports];
  logic [15:0] slot_from [Ports*Depth];
  logic [31:0] slot_kind [Ports*Depth];
  logic [3:0]  slot_len [Ports*Depth];
  logic [63:0] slot_bytes [Ports*Depth];
  logic [31:0] mb_sent;

  mbx_word_t  pending_words[$];
  mbx_reply_t expected_replies[$];
  int unsigned words_queued, words_taken, replies_checked, failures;
  int unsigned cmd_seen [8];
  int unsigned stuck_cycles;
  int unsigned in_gap, out_gap;
  logic        word_taken;
  logic        quiet;
  logic [15:0] pid_pool [6];

  // Computes the reply to one command word and advances the shadow state.
  function automatic mbx_reply_t predict_reply(mbx_word_t w);
    mbx_reply_t r;
    logic       port_ok;
    logic       owned;
    int         s;
    logic [63:0] keep;
    r = '0;
    r.status = ST_ERR;
    port_ok = w.port < Ports;
    owned = port_ok && mb_in_use[w.port[3:0]] && mb_owner[w.port[3:0]] == w.pid;
    case (w.cmd)
      CMD_CREATE: begin
        for (int i = 0; i < Ports; i++) begin
          if (!mb_in_use[i] && r.status == ST_ERR) begin
            mb_in_use[i] = 1'b1;
            mb_owner[i] = w.pid;
            mb_head[i] = '0;
            mb_tail[i] = '0;
            mb_count[i] = '0;
            mb_waiting[i] = 1'b0;
            r.status = ST_OK;
            r.port_out = 4'(i);
          end
        end
      end
      CMD_DESTROY: begin
        if (owned) begin
          // The waiter of a destroyed port is released.
          if (mb_waiting[w.port]) begin
            r.wake_valid = 1'b1;
            r.wake_pid = mb_waiter[w.port];
            mb_waiting[w.port] = 1'b0;
          end
          mb_in_use[w.port] = 1'b0;
          mb_owner[w.port] = '0;
          mb_count[w.port] = '0;
          r.status = ST_OK;
        end
      end
      CMD_SEND: begin
        if (port_ok && mb_in_use[w.port[3:0]] && w.size <= MsgBytesDef
            && mb_count[w.port[3:0]] < Depth) begin
          s = w.port * Depth + mb_tail[w.port];
          keep = (w.size >= 8) ? '1 : ((64'd1 << (8 * w.size)) - 64'd1);
          slot_from[s] = w.pid;
          slot_kind[s] = w.mtype;
          slot_len[s] = w.size[3:0];
          slot_bytes[s] = w.data & keep;
          mb_tail[w.port] = mb_tail[w.port] + 4'd1;
          mb_count[w.port] = mb_count[w.port] + 5'd1;
          mb_sent = mb_sent + 32'd1;
          if (mb_waiting[w.port]) begin
            r.wake_valid = 1'b1;
            r.wake_pid = mb_waiter[w.port];
            mb_waiting[w.port] = 1'b0;
          end
          r.status = ST_OK;
        end
      end
      CMD_RECV, CMD_TRYRECV: begin
        if (owned) begin
          if (mb_count[w.port] == 0) begin
            if (w.cmd == CMD_RECV) begin
              // A new blocking receiver silently replaces an old one.
              mb_waiting[w.port] = 1'b1;
              mb_waiter[w.port] = w.pid;
              r.status = ST_BLOCKED;
            end else begin
              r.status = ST_EMPTY;
            end
          end else begin
            s = w.port * Depth + mb_head[w.port];
            r.sender = slot_from[s];
            r.rtype = slot_kind[s];
            r.rsize = slot_len[s];
            r.rdata = slot_bytes[s];
            mb_head[w.port] = mb_head[w.port] + 4'd1;
            mb_count[w.port] = mb_count[w.port] - 5'd1;
            r.status = ST_OK;
          end
        end
      end
      CMD_STATS: begin
        for (int i = 0; i < Ports; i++) begin
          if (mb_in_use[i]) begin
            r.active = r.active + 5'd1;
            if (mb_waiting[i]) r.blocked = r.blocked + 5'd1;
          end
        end
        r.total = mb_sent;
        r.status = ST_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  function automatic void queue_word(logic [2:0] cmd, logic [15:0] pid, logic [7:0] port,
                                     logic [7:0] size);
    mbx_word_t w;
    w.cmd = cmd;
    w.pid = pid;
    w.port = port;
    w.mtype = $urandom;
    w.size = size;
    w.data = {$urandom, $urandom};
    pending_words.push_back(w);
    words_queued++;
  endfunction

  // Returns a port in use, or -1 when none is.
  function automatic int pick_used_port();
    int start;
    start = $urandom_range(Ports - 1);
    for (int k = 0; k < Ports; k++) begin
      if (mb_in_use[(start + k) % Ports]) return (start + k) % Ports;
    end
    return -1;
  endfunction

  function automatic logic [7:0] pick_size();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd8;
      2: return 8'($urandom_range(255, 9));
      default: return 8'($urandom_range(8));
    endcase
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Driver: new words and idle bursts are applied at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || word_taken) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!quiet && $urandom_range(5) == 0) begin
          in_gap <= $urandom_range(8, 1) - 1;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          mbx_word_t w;
          w = pending_words.pop_front();
          in_valid_i <= 1'b1;
          cmd_i <= w.cmd;
          caller_pid_i <= w.pid;
          port_i <= w.port;
          msg_type_i <= w.mtype;
          msg_size_i <= w.size;
          payload_i <= w.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      // Result side stalls in bursts of its own.
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(5) == 0) begin
        out_gap <= $urandom_range(8, 1) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: both handshakes are sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      word_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        expected_replies.push_back(predict_reply({cmd_i, caller_pid_i, port_i, msg_type_i,
                                                  msg_size_i, payload_i}));
        words_taken++;
        cmd_seen[cmd_i]++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_replies.size() == 0) begin
          $error("reply with no word outstanding");
          failures++;
        end else begin
          mbx_reply_t e;
          e = expected_replies.pop_front();
          check_field("status", e.status, status_o);
          check_field("port_out", e.port_out, port_out_o);
          check_field("msg_sender", e.sender, msg_sender_o);
          check_field("recv_type", e.rtype, recv_type_o);
          check_field("recv_size", e.rsize, recv_size_o);
          check_field("recv_payload", e.rdata, recv_payload_o);
          check_field("wake_valid", e.wake_valid, wake_valid_o);
          check_field("wake_pid", e.wake_pid, wake_pid_o);
          check_field("ports_used", e.active, ports_used_o);
          check_field("blocked_ports", e.blocked, blocked_ports_o);
          check_field("msg_count", e.total, msg_count_o);
          replies_checked++;
        end
      end
      // Watchdog over cycles in which neither channel moves.
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= StuckLimit) begin
        $display("[mailbox_port_queue_engine] ERROR");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    int p;
    int n;
    logic [15:0] who;
    for (int i = 0; i < Ports; i++) begin
      mb_in_use[i] = 0; mb_owner[i] = 0; mb_head[i] = 0; mb_tail[i] = 0;
      mb_count[i] = 0; mb_waiting[i] = 0; mb_waiter[i] = 0;
    end
    mb_sent = '0;
    word_taken = 1'b0;
    quiet = 1'b0;
    stuck_cycles = 0;
    in_gap = 0;
    out_gap = 0;
    foreach (pid_pool[i]) pid_pool[i] = 16'($urandom);
    pid_pool[0] = 16'h0000;
    pid_pool[1] = 16'hFFFF;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening: two ports at the pid extremes, size limits, errors,
    // blocking and waking, waiter replacement and destroy with a waiter.
    queue_word(CMD_CREATE, 16'h0000, 8'd0, 8'd0);
    queue_word(CMD_CREATE, 16'hFFFF, 8'd0, 8'd0);
    queue_word(CMD_SEND, 16'h1234, 8'd0, 8'd0);
    queue_word(CMD_SEND, 16'hFFFF, 8'd0, 8'd8);
    queue_word(CMD_SEND, 16'h0001, 8'd0, 8'd9);
    queue_word(CMD_SEND, 16'h0001, 8'd0, 8'd255);
    queue_word(CMD_SEND, 16'h0002, 8'd0, 8'd3);
    queue_word(CMD_RECV, 16'hFFFF, 8'd0, 8'd0);
    queue_word(CMD_RECV, 16'h0000, 8'd0, 8'd0);
    queue_word(CMD_TRYRECV, 16'h0000, 8'd0, 8'd0);
    queue_word(CMD_TRYRECV, 16'h0000, 8'd0, 8'd0);
    queue_word(CMD_TRYRECV, 16'h0000, 8'd0, 8'd0);
    queue_word(CMD_RECV, 16'h0000, 8'd0, 8'd0);
    queue_word(CMD_RECV, 16'h0000, 8'd0, 8'd0);
    queue_word(CMD_STATS, 16'h0000, 8'd0, 8'd0);
    queue_word(CMD_SEND, 16'h5555, 8'd0, 8'd5);
    queue_word(CMD_RECV, 16'hFFFF, 8'd1, 8'd0);
    queue_word(CMD_DESTROY, 16'h0000, 8'd1, 8'd0);
    queue_word(CMD_SEND, 16'h0003, 8'd16, 8'd1);
    queue_word(CMD_SEND, 16'h0003, 8'd255, 8'd1);
    queue_word(CMD_SEND, 16'h0003, 8'd2, 8'd1);
    queue_word(CMD_UNUSED_LO, 16'h0000, 8'd0, 8'd0);
    queue_word(CMD_UNUSED_HI, 16'hFFFF, 8'd255, 8'd255);
    queue_word(CMD_DESTROY, 16'hFFFF, 8'd1, 8'd0);
    queue_word(CMD_STATS, 16'h0000, 8'd0, 8'd0);

    // Random part in short scenarios; each batch is built from the shadow
    // state after the previous batch has fully drained.
    while (words_queued < WordTarget) begin
      while (pending_words.size() > 0 || expected_replies.size() > 0 || in_valid_i)
        @(posedge clk_i);
      if (words_queued >= QuietFrom) quiet = 1'b1;
      p = pick_used_port();
      case ((p < 0) ? 0 : $urandom_range(9))
        0: begin
          n = $urandom_range(3) == 0 ? 17 : $urandom_range(4, 1);
          repeat (n) queue_word(CMD_CREATE, pid_pool[$urandom_range(5)], 8'($urandom),
                                8'($urandom));
        end
        1: begin
          if ($urandom_range(1)) queue_word(CMD_RECV, mb_owner[p], 8'(p), 8'd0);
          queue_word(CMD_DESTROY, $urandom_range(3) == 0 ? 16'($urandom) : mb_owner[p],
                     8'(p), 8'd0);
        end
        2, 3: begin
          n = $urandom_range(4) == 0 ? 18 : $urandom_range(5, 1);
          repeat (n) queue_word(CMD_SEND, pid_pool[$urandom_range(5)], 8'(p), pick_size());
          repeat ($urandom_range(n)) queue_word($urandom_range(1) ? CMD_RECV : CMD_TRYRECV,
                                                mb_owner[p], 8'(p), 8'd0);
        end
        4, 5: begin
          // Block, maybe replace the waiter, then wake it with a send.
          repeat (mb_count[p] + 1) queue_word(CMD_RECV, mb_owner[p], 8'(p), 8'd0);
          if ($urandom_range(2) == 0) queue_word(CMD_RECV, mb_owner[p], 8'(p), 8'd0);
          queue_word(CMD_STATS, 16'($urandom), 8'($urandom), 8'($urandom));
          queue_word(CMD_SEND, 16'($urandom), 8'(p), pick_size());
          queue_word(CMD_RECV, mb_owner[p], 8'(p), 8'd0);
        end
        6: begin
          who = $urandom_range(1) ? mb_owner[p] : 16'($urandom);
          repeat ($urandom_range(3, 1))
            queue_word($urandom_range(1) ? CMD_RECV : CMD_TRYRECV, who, 8'(p), 8'd0);
        end
        7: begin
          repeat ($urandom_range(4, 1)) begin
            queue_word(3'($urandom_range(7)), 16'($urandom),
                       $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(Ports - 1)),
                       8'($urandom));
          end
        end
        default: queue_word(CMD_STATS, pid_pool[$urandom_range(5)], 8'($urandom), 8'd0);
      endcase
    end

    while (pending_words.size() > 0 || expected_replies.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_replies.size() > 0) begin
      $error("%0d expected replies never arrived", expected_replies.size());
      failures++;
    end
    $display("Covered %0d words (create %0d, destroy %0d, send %0d, receive %0d, try %0d,",
             words_taken, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4]);
    $display("stats %0d, unknown %0d); %0d replies checked, %0d messages sent.",
             cmd_seen[5], cmd_seen[6] + cmd_seen[7], replies_checked, mb_sent);
    if (failures == 0) begin
      $display("[mailbox_port_queue_engine] OK");
    end else begin
      $display("[mailbox_port_queue_engine] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mpqe_pkg.sv
rtl/mpqe_slot_ram.sv
rtl/mailbox_port_queue_engine.sv
bench/tb.sv
